>>> sv/http_chunked_body_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shorthand for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HCBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication.
`define HCBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

>>> sv/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared widths, codes, result struct and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} result_kind_t;

	typedef enum logic [3:0] {
		PH_SIZE    = 4'b0001,
		PH_DATA    = 4'b0010,
		PH_SKIP    = 4'b0100,
		PH_TRAILER = 4'b1000
	} phase_t;

	typedef struct packed {
		logic         valid;
		result_kind_t kind;
		logic [7:0]   body;
	} hcbd_result_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t d;
		d.is_hex = 1'b0;
		d.value  = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d.is_hex = 1'b1;
			d.value  = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d.is_hex = 1'b1;
			d.value  = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d.is_hex = 1'b1;
			d.value  = 4'(b - 8'h37);
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> sv/hcbd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder channels
// Valid/ready channels for raw body bytes and for decoded results.
// ----------------------------------------------------------------------------
interface hcbd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface hcbd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] body_byte;

	modport source (output valid, output result_kind, output body_byte, input ready);
	modport sink (input valid, input result_kind, input body_byte, output ready);
endinterface
`default_nettype wire

>>> sv/hcbd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body parser
// Holds the framing state and decodes one byte per step into at most one result.
// ----------------------------------------------------------------------------
module hcbd_parser
	import hcbd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   byte_in,
	output hcbd_result_t      res
);

	phase_t                 phase_q, phase_d;
	logic [SIZE_BITS-1:0]   acc_q, acc_d;
	logic [SIZE_BITS-1:0]   left_q, left_d;
	logic                   hex_stop_q, hex_stop_d;
	logic                   cr_q, cr_d;
	logic                   tne_q, tne_d;

	hex_digit_t             hx;
	phase_t                 line_phase;
	logic                   is_size;
	logic                   stopped;
	logic                   overflow;

	assign hx = hex_decode(byte_in);
	// Shifting in another digit overflows once any of the top four bits is set.
	assign overflow = |acc_q[SIZE_BITS-1 -: 4];

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		left_d     = left_q;
		hex_stop_d = hex_stop_q;
		cr_d       = cr_q;
		tne_d      = tne_q;
		res        = '{valid: 1'b0, kind: KIND_BYTE, body: 8'd0};
		line_phase = PH_SIZE;
		is_size    = 1'b0;
		stopped    = 1'b0;

		case (phase_q)
			PH_DATA: begin
				res.valid = 1'b1;
				res.body  = byte_in;
				left_d    = left_q - SIZE_BITS'(1);
				if (left_q == SIZE_BITS'(1)) begin
					phase_d = PH_SKIP;
					cr_d    = 1'b0;
				end
			end
			default: begin
				line_phase = (phase_q == PH_SKIP || phase_q == PH_TRAILER) ? phase_q : PH_SIZE;
				is_size    = (line_phase == PH_SIZE);
				phase_d    = line_phase;
				if (cr_q && byte_in == CHAR_LF) begin
					cr_d = 1'b0;
					case (line_phase)
						PH_SKIP: begin
							phase_d    = PH_SIZE;
							acc_d      = '0;
							hex_stop_d = 1'b0;
						end
						PH_TRAILER: begin
							if (tne_q) begin
								tne_d = 1'b0;
							end else begin
								phase_d    = PH_SIZE;
								acc_d      = '0;
								hex_stop_d = 1'b0;
								res.valid  = 1'b1;
								res.kind   = KIND_END;
							end
						end
						default: begin
							if (acc_q == '0) begin
								phase_d = PH_TRAILER;
								tne_d   = 1'b0;
							end else begin
								phase_d = PH_DATA;
								left_d  = acc_q;
							end
							acc_d      = '0;
							hex_stop_d = 1'b0;
						end
					endcase
				end else begin
					// A carriage return not followed by a line feed counts as line content.
					stopped = hex_stop_q || cr_q;
					if (cr_q) begin
						tne_d = 1'b1;
						if (is_size) begin
							hex_stop_d = 1'b1;
						end
					end
					if (byte_in == CHAR_CR) begin
						cr_d = 1'b1;
					end else begin
						cr_d  = 1'b0;
						tne_d = 1'b1;
						if (is_size && !stopped) begin
							if (!hx.is_hex) begin
								hex_stop_d = 1'b1;
							end else if (overflow) begin
								phase_d    = PH_SIZE;
								acc_d      = '0;
								hex_stop_d = 1'b0;
								cr_d       = 1'b0;
								tne_d      = 1'b0;
								res.valid  = 1'b1;
								res.kind   = KIND_ERROR;
							end else begin
								acc_d = {acc_q[SIZE_BITS-5:0], hx.value};
							end
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIZE;
			acc_q      <= '0;
			left_q     <= '0;
			hex_stop_q <= 1'b0;
			cr_q       <= 1'b0;
			tne_q      <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			left_q     <= left_d;
			hex_stop_q <= hex_stop_d;
			cr_q       <= cr_d;
			tne_q      <= tne_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Strips chunk size lines, chunk delimiters and trailers from a chunked body
// stream and delivers payload bytes, end-of-message and size overflow results.
// ----------------------------------------------------------------------------
// Path: an accepted byte beat passes through the input register, then the result
// register, before its result is offered.
// Throughput: one byte beat per cycle; input stalls only while a result waits.
// Reset: arst_n clears all control and framing state asynchronously; the
// decoder then expects a chunk size line.
module http_chunked_body_decoder_top
	import hcbd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	hcbd_byte_if.sink         stream,
	hcbd_result_if.source     result
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         res_ready;
	logic         step;
	hcbd_result_t res;

	logic         out_valid_q;
	result_kind_t kind_q;
	logic [7:0]   body_q;

	// The result register can load when it is empty or being drained this cycle.
	assign res_ready    = !out_valid_q || result.ready;
	assign step         = valid_s1 && res_ready;
	assign stream.ready = !valid_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.byte_in;
		end
	end

	hcbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q <= res.kind;
			body_q <= res.body;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = kind_q;
	assign result.body_byte   = body_q;

endmodule
`default_nettype wire

>>> sv/hcbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder port checker
// Watches the top-level channels for result encoding and flow control slips.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_top_assert.svh"

module hcbd_checker
	import hcbd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] out_kind,
	input wire logic [7:0] out_body
);

	logic        out_stall;
	logic [9:0]  out_beat;
	logic        kind_ok;
	logic        in_stall;

	assign out_stall = out_valid && !out_ready;
	assign out_beat  = {out_kind, out_body};
	assign kind_ok   = out_kind == KIND_BYTE || out_kind == KIND_END || out_kind == KIND_ERROR;
	assign in_stall  = in_valid && !in_ready;

	// A stalled result beat holds its contents.
	`HCBD_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_beat))

	// Only the three defined result kinds are ever offered.
	`HCBD_ASSERT_IMP(a_kind_legal, clk, arst_n, out_valid, kind_ok)

	// End-of-message and error results carry a zero body byte.
	`HCBD_ASSERT_IMP(a_body_zero, clk, arst_n, out_valid && out_kind != KIND_BYTE, out_body == 8'd0)

	// With no result waiting, the input side is never held off.
	`HCBD_ASSERT_IMP(a_in_free, clk, arst_n, !out_valid, in_ready)

	// A held-off input beat always has a result beat waiting ahead of it.
	`HCBD_ASSERT_IMP(a_in_stall_cause, clk, arst_n, in_stall, out_valid)

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (stream.valid),
	.in_ready  (stream.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.result_kind),
	.out_body  (result.body_byte)
);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Feeds chunked-encoded byte streams into the decoder: a directed opening,
// then random messages, malformed lines, size overflows and cut-off messages.
// A scoreboard tracks the framing state of the stream, queues the payload,
// end-of-message and error results that each byte causes, and compares every
// result beat with the oldest queued one.
// ----------------------------------------------------------------------------
module tb;
	import hcbd_pkg::*;

	localparam int ITEMS = 750;

	typedef struct {
		result_kind_t kind;
		logic [7:0]   body;
	} body_result_t;

	class body_scoreboard;
		phase_t                phase;
		logic [SIZE_BITS-1:0]  size_acc;
		logic [SIZE_BITS-1:0]  bytes_left;
		bit                    hex_stopped;
		bit                    cr_seen;
		bit                    trailer_busy;
		body_result_t          pending[$];
		int                    errors;

		function new();
			clear_line();
			bytes_left   = '0;
			trailer_busy = 1'b0;
			errors       = 0;
		endfunction

		static function int hex_value(logic [7:0] b);
			if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
			if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
			if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
			return -1;
		endfunction

		function void clear_line();
			phase       = PH_SIZE;
			size_acc    = '0;
			hex_stopped = 1'b0;
			cr_seen     = 1'b0;
		endfunction

		// Returns 0 when the digit would push the size past its width.
		function bit size_char(logic [7:0] b);
			int                   d;
			logic [SIZE_BITS+3:0] grown;
			if (hex_stopped) return 1'b1;
			d = hex_value(b);
			if (d < 0) begin
				hex_stopped = 1'b1;
				return 1'b1;
			end
			grown = {size_acc, 4'b0} + (SIZE_BITS+4)'(d);
			if (grown[SIZE_BITS+3:SIZE_BITS] != 4'd0) return 1'b0;
			size_acc = grown[SIZE_BITS-1:0];
			return 1'b1;
		endfunction

		function void add(result_kind_t k, logic [7:0] b);
			body_result_t r;
			r.kind = k;
			r.body = b;
			pending = {pending, r};
		endfunction

		function void note_byte(logic [7:0] b);
			bit ok;
			ok = 1'b1;
			if (phase == PH_DATA) begin
				add(KIND_BYTE, b);
				bytes_left = bytes_left - SIZE_BITS'(1);
				if (bytes_left == '0) begin
					phase   = PH_SKIP;
					cr_seen = 1'b0;
				end
				return;
			end
			if (phase != PH_SKIP && phase != PH_TRAILER) phase = PH_SIZE;
			if (!(cr_seen && b == CHAR_LF)) begin
				// A CR that is not followed by LF is ordinary line content.
				if (cr_seen) begin
					if (phase == PH_SIZE) void'(size_char(CHAR_CR));
					trailer_busy = 1'b1;
				end
				if (b == CHAR_CR) begin
					cr_seen = 1'b1;
				end else begin
					cr_seen = 1'b0;
					if (phase == PH_SIZE) ok = size_char(b);
					trailer_busy = 1'b1;
				end
				if (!ok) begin
					clear_line();
					trailer_busy = 1'b0;
					add(KIND_ERROR, 8'h00);
				end
				return;
			end
			cr_seen = 1'b0;
			case (phase)
				PH_SIZE: begin
					if (size_acc == '0) begin
						phase        = PH_TRAILER;
						trailer_busy = 1'b0;
					end else begin
						phase      = PH_DATA;
						bytes_left = size_acc;
					end
					size_acc    = '0;
					hex_stopped = 1'b0;
				end
				PH_SKIP: clear_line();
				default: begin
					if (trailer_busy) begin
						trailer_busy = 1'b0;
					end else begin
						clear_line();
						add(KIND_END, 8'h00);
					end
				end
			endcase
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] body);
			body_result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d body %02h",
					$time, kind, body);
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind) begin
				errors++;
				$display("%0t: result_kind mismatch, expected %0d, actual %0d",
					$time, e.kind, kind);
			end
			if (body !== e.body) begin
				errors++;
				$display("%0t: body_byte mismatch, expected %02h, actual %02h",
					$time, e.body, body);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hcbd_byte_if   stream_if();
	hcbd_result_if result_if();

	http_chunked_body_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	body_scoreboard sb;
	// A second copy follows the stream as it is built, so the generator
	// knows where the decoder will stand after each byte.
	body_scoreboard plan;
	logic [7:0]     stim[$];
	int             cut_left = -1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void push_byte(logic [7:0] b);
		if (cut_left == 0) return;
		if (cut_left > 0) cut_left--;
		stim = {stim, b};
		plan.note_byte(b);
		plan.pending.delete();
	endfunction

	function automatic void push_text(string s);
		foreach (s[i]) push_byte(s[i]);
	endfunction

	// Line content that never completes a CRLF.
	function automatic void push_filler(int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (plan.cr_seen && b == CHAR_LF) b = 8'h20;
			push_byte(b);
		end
	endfunction

	// Random bytes, except that a digit that would open a large chunk is
	// swapped for a non-hex byte.
	function automatic void push_noise(int n);
		logic [7:0] b;
		int         d;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			d = body_scoreboard::hex_value(b);
			if (plan.phase == PH_SIZE && !plan.cr_seen && !plan.hex_stopped && d >= 0 &&
				longint'(plan.size_acc) * 16 + d > 64)
				b = 8'h47;
			push_byte(b);
		end
	endfunction

	function automatic logic [7:0] hex_char(int v);
		if (v < 10) return 8'(8'h30 + v);
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic void push_size(int unsigned v, int zeros);
		int nd;
		repeat (zeros) push_byte(8'h30);
		nd = 1;
		while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
		for (int k = nd - 1; k >= 0; k--) push_byte(hex_char((v >> (4 * k)) & 15));
	endfunction

	function automatic void push_extension();
		if ($urandom_range(0, 3) == 0) begin
			push_byte(8'h3B);
			push_filler($urandom_range(0, 6));
		end else if ($urandom_range(0, 9) == 0) begin
			push_byte(8'h20);
			push_filler($urandom_range(0, 4));
		end
	endfunction

	function automatic void gen_chunk(int unsigned size);
		push_size(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
		push_extension();
		push_text("\r\n");
		repeat (size) push_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) == 0) push_filler($urandom_range(1, 4));
		push_text("\r\n");
	endfunction

	function automatic void gen_message();
		repeat ($urandom_range(0, 4))
			gen_chunk(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
		// The last chunk sometimes has an empty size line, which also means zero.
		if ($urandom_range(0, 9) != 0) push_size(0, $urandom_range(0, 2));
		push_extension();
		push_text("\r\n");
		repeat ($urandom_range(0, 2)) begin
			push_filler($urandom_range(1, 6));
			push_text("\r\n");
		end
		push_text("\r\n");
	endfunction

	// Nine digits with a nonzero lead cannot fit in the size.
	function automatic void gen_overflow();
		push_byte(hex_char($urandom_range(1, 15)));
		repeat (8) push_byte(hex_char($urandom_range(0, 15)));
		push_noise($urandom_range(0, 3));
	endfunction

	// Brings the stream back to the start of a fresh size line.
	function automatic void resync();
		while (!(plan.phase == PH_SIZE && plan.size_acc == '0 && !plan.hex_stopped &&
			!plan.cr_seen)) begin
			if (plan.phase == PH_DATA) push_byte(8'($urandom_range(0, 255)));
			else push_byte(plan.cr_seen ? CHAR_LF : CHAR_CR);
		end
	endfunction

	function automatic void build_stimulus();
		int sel;
		// One two-byte chunk with extreme payload values, the last chunk, a
		// trailer line holding a bare CR, the closing empty line, and an
		// oversized chunk size.
		push_text("2\r\n");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("\r\n0\r\nX\r\r\n\r\n");
		push_text("1fFfFfFfF");
		resync();
		while (stim.size() < ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				gen_message();
			end else if (sel < 82) begin
				push_noise($urandom_range(1, 8));
			end else if (sel < 90) begin
				gen_overflow();
			end else begin
				cut_left = $urandom_range(1, 30);
				gen_message();
				cut_left = -1;
				push_noise($urandom_range(0, 3));
			end
			resync();
		end
	endfunction

	task automatic drive_bytes();
		int gap;
		bit steady;
		steady = 1'b0;
		foreach (stim[i]) begin
			if ($urandom_range(0, 39) == 0) steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				stream_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			stream_if.valid   <= 1'b1;
			stream_if.byte_in <= stim[i];
			@(posedge clk);
			while (!stream_if.ready) @(posedge clk);
			sb.note_byte(stim[i]);
		end
		stream_if.valid <= 1'b0;
	endtask

	task automatic take_results();
		int gap;
		bit steady;
		steady = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0) steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			@(posedge clk);
			while (!result_if.valid) @(posedge clk);
			sb.check_result(result_if.result_kind, result_if.body_byte);
		end
	endtask

	initial begin
		int waited;
		sb   = new();
		plan = new();
		arst_n            <= 1'b0;
		stream_if.valid   <= 1'b0;
		stream_if.byte_in <= 8'h00;
		result_if.ready   <= 1'b0;
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		fork
			take_results();
		join_none
		drive_bytes();
		waited = 0;
		while (sb.pending.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d results missing, expected kind %0d body %02h, actual none",
				$time, sb.pending.size(), sb.pending[0].kind, sb.pending[0].body);
		end
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> http_chunked_body_decoder_top.f
+incdir+sv
sv/hcbd_pkg.sv
sv/hcbd_ifs.sv
sv/hcbd_parser.sv
sv/http_chunked_body_decoder_top.sv
sv/hcbd_checker.sv
tb/sv/tb.sv
